// ===== sv/bqem_pkg.sv =====
// Shared types, constants and reference shape tables for the bilinear quad element map.
package bqem_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int CONST_FRAC = 30;
  localparam int DIV_SHIFT  = CONST_FRAC - FRAC_BITS;
  localparam int QDEPTH     = 2;

  localparam logic signed [31:0] K_DP  = 32'sd423416739;
  localparam logic signed [31:0] K_DM  = 32'sd113454173;
  localparam logic signed [31:0] K_VPP = 32'sd667876507;
  localparam logic signed [31:0] K_VPM = 32'sd178956971;
  localparam logic signed [31:0] K_VMM = 32'sd47951376;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    KIND_VAL,
    KIND_DX,
    KIND_DY
  } coef_kind_t;

  typedef struct packed {
    logic signed [31:0] corner0_x;
    logic signed [31:0] corner0_y;
    logic signed [31:0] corner1_x;
    logic signed [31:0] corner1_y;
    logic signed [31:0] corner2_x;
    logic signed [31:0] corner2_y;
    logic signed [31:0] corner3_x;
    logic signed [31:0] corner3_y;
  } in_t;

  typedef struct packed {
    logic [1:0]         gauss_index;
    logic [1:0]         basis_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] jacobian_det;
    logic signed [31:0] deriv_x;
    logic signed [31:0] deriv_y;
    logic               degenerate;
    logic               last;
  } out_t;

  function automatic logic pos_x(input logic [1:0] i);
    return (i == 2'd1) || (i == 2'd2);
  endfunction

  function automatic logic pos_y(input logic [1:0] i);
    return i[1];
  endfunction

  function automatic logic signed [31:0] ref_coef(input coef_kind_t kind,
                                                  input logic [1:0] n,
                                                  input logic [1:0] g);
    logic sx;
    logic sy;
    logic signed [31:0] m;
    sx = pos_x(n) == pos_x(g);
    sy = pos_y(n) == pos_y(g);
    unique case (kind)
      KIND_VAL: begin
        if (sx && sy) m = K_VPP;
        else if (!sx && !sy) m = K_VMM;
        else m = K_VPM;
      end
      KIND_DX: begin
        m = sy ? K_DP : K_DM;
        if (!pos_x(n)) m = -m;
      end
      KIND_DY: begin
        m = sx ? K_DP : K_DM;
        if (!pos_y(n)) m = -m;
      end
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/bqem_front.sv =====
// Input queue: accepts element beats and holds them for the back end.
module bqem_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  bqem_pkg::in_t  corners,
  output logic           q_valid,
  input  logic           q_pop,
  output bqem_pkg::in_t  q_data
);

  localparam int PW = $clog2(bqem_pkg::QDEPTH);
  localparam int CW = $clog2(bqem_pkg::QDEPTH + 1);

  bqem_pkg::in_t mem [bqem_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign busy    = count == CW'(bqem_pkg::QDEPTH);
  assign q_valid = count != '0;
  assign push    = start && !busy;
  assign pop     = q_pop && q_valid;
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= corners;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(bqem_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(bqem_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

// ===== sv/bqem_div.sv =====
// Iterative rounded fixed point divider with saturation, one quotient bit per cycle.
module bqem_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  localparam int UDW = 32 + bqem_pkg::DIV_SHIFT;
  localparam int QW  = 34;
  localparam int DW  = UDW + QW;

  logic [DW-1:0]  rem;
  logic [DW-1:0]  dsh;
  logic [QW-1:0]  q;
  logic [5:0]     cnt;
  logic           neg;
  logic [63:0]    un;
  logic [31:0]    ud;
  logic [UDW-1:0] udw;
  logic           ge;
  logic [QW-1:0]  q_next;

  assign un     = num[63] ? 64'(~num + 64'sd1) : 64'(num);
  assign ud     = den[31] ? 32'(~den + 32'sd1) : 32'(den);
  assign udw    = {ud, {bqem_pkg::DIV_SHIFT{1'b0}}};
  assign ge     = rem >= dsh;
  assign q_next = {q[QW-2:0], ge};

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DW'(un) + DW'(udw >> 1);
      dsh <= DW'(udw) << (QW - 1);
      q   <= '0;
      neg <= num[63] ^ den[31];
    end else if (cnt != '0) begin
      if (ge) rem <= rem - dsh;
      dsh <= dsh >> 1;
      q   <= q_next;
    end
    if (cnt == 6'd1) begin
      if (neg) begin
        quo <= (q_next > QW'(34'd2147483648)) ? bqem_pkg::SAT_MIN : 32'(~q_next[31:0] + 1'b1);
      end else begin
        quo <= (q_next > QW'(34'd2147483647)) ? bqem_pkg::SAT_MAX : 32'(q_next[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= cnt == 6'd1;
      if (start) cnt <= 6'(QW);
      else if (cnt != '0) cnt <= cnt - 1'b1;
    end
  end

endmodule

// ===== sv/bqem_back.sv =====
// Back end sequencer: Jacobian, determinant, numerators and result beats per element.
module bqem_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_pop,
  input  bqem_pkg::in_t  q_data,
  output logic           result_valid,
  output bqem_pkg::out_t result
);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_ACCW, S_RND, S_D0, S_D1, S_D2,
    S_N0, S_N1, S_N2, S_N3, S_N4, S_DIV
  } state_t;

  state_t state;
  logic signed [31:0] cx [4];
  logic signed [31:0] cy [4];
  logic signed [63:0] acc [6];
  logic [4:0]  k;
  logic [1:0]  g;
  logic [1:0]  n;
  logic        pv;
  logic [2:0]  ptgt;
  logic        pfirst;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] tmp;
  logic signed [63:0] nx;
  logic signed [63:0] ny_next;
  logic signed [31:0] px, py, ja, jb, jc, jd, det;
  logic        degen;
  logic [2:0]  qty;
  logic        is_y;
  bqem_pkg::coef_kind_t kind;
  logic signed [31:0] rx;
  logic signed [31:0] ry;
  logic        div_start;
  logic        dx_done;
  logic        dy_done;
  logic signed [31:0] dx_q;
  logic signed [31:0] dy_q;
  logic signed [64:0] det_diff;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) return bqem_pkg::SAT_MAX;
    if (v < -65'sd2147483648) return bqem_pkg::SAT_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat32_sym(input logic signed [64:0] v);
    if (v > 65'sd2147483647) return bqem_pkg::SAT_MAX;
    if (v < -65'sd2147483647) return -bqem_pkg::SAT_MAX;
    return v[31:0];
  endfunction

  function automatic logic signed [64:0] rnd30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'sd536870912;
    return 65'(t >>> bqem_pkg::CONST_FRAC);
  endfunction

  assign qty  = k[4:2];
  assign is_y = (qty == 3'd1) || (qty == 3'd4) || (qty == 3'd5);
  assign rx   = bqem_pkg::ref_coef(bqem_pkg::KIND_DX, n, g);
  assign ry   = bqem_pkg::ref_coef(bqem_pkg::KIND_DY, n, g);
  assign ny_next   = tmp - prod;
  assign det_diff  = 65'(tmp) - 65'(prod) + (65'sd1 <<< (bqem_pkg::FRAC_BITS - 1));
  assign div_start = (state == S_N4) && !degen;

  always_comb begin
    unique case (qty)
      3'd0, 3'd1: kind = bqem_pkg::KIND_VAL;
      3'd2, 3'd4: kind = bqem_pkg::KIND_DX;
      default:    kind = bqem_pkg::KIND_DY;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_ACC: begin
        mul_a = is_y ? cy[k[1:0]] : cx[k[1:0]];
        mul_b = bqem_pkg::ref_coef(kind, k[1:0], g);
      end
      S_D0: begin mul_a = ja; mul_b = jd; end
      S_D1: begin mul_a = jb; mul_b = jc; end
      S_N0: begin mul_a = rx; mul_b = jd; end
      S_N1: begin mul_a = ry; mul_b = jc; end
      S_N2: begin mul_a = ry; mul_b = ja; end
      S_N3: begin mul_a = rx; mul_b = jb; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  bqem_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .num(nx), .den(det),
    .done(dx_done), .quo(dx_q)
  );

  bqem_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .num(ny_next), .den(det),
    .done(dy_done), .quo(dy_q)
  );

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (pv) acc[ptgt] <= pfirst ? prod : acc[ptgt] + prod;
    if (q_pop) begin
      cx[0] <= q_data.corner0_x; cy[0] <= q_data.corner0_y;
      cx[1] <= q_data.corner1_x; cy[1] <= q_data.corner1_y;
      cx[2] <= q_data.corner2_x; cy[2] <= q_data.corner2_y;
      cx[3] <= q_data.corner3_x; cy[3] <= q_data.corner3_y;
    end
    unique case (state)
      S_RND: begin
        px <= sat32(rnd30(acc[0]));
        py <= sat32(rnd30(acc[1]));
        ja <= sat32_sym(rnd30(acc[2]));
        jb <= sat32_sym(rnd30(acc[3]));
        jc <= sat32_sym(rnd30(acc[4]));
        jd <= sat32_sym(rnd30(acc[5]));
      end
      S_D1: tmp <= prod;
      S_D2: begin
        det   <= sat32(det_diff >>> bqem_pkg::FRAC_BITS);
        degen <= sat32(det_diff >>> bqem_pkg::FRAC_BITS) == '0;
      end
      S_N1: tmp <= prod;
      S_N2: nx <= tmp - prod;
      S_N3: tmp <= prod;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      pv           <= 1'b0;
      k            <= '0;
      g            <= '0;
      n            <= '0;
    end else begin
      result_valid <= 1'b0;
      pv           <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            g     <= '0;
            n     <= '0;
            k     <= '0;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          pv     <= 1'b1;
          ptgt   <= qty;
          pfirst <= k[1:0] == 2'd0;
          k      <= k + 1'b1;
          if (k == 5'd23) state <= S_ACCW;
        end
        S_ACCW: state <= S_RND;
        S_RND:  state <= S_D0;
        S_D0:   state <= S_D1;
        S_D1:   state <= S_D2;
        S_D2: begin
          n     <= '0;
          state <= S_N0;
        end
        S_N0: state <= S_N1;
        S_N1: state <= S_N2;
        S_N2: state <= S_N3;
        S_N3: state <= S_N4;
        S_N4, S_DIV: begin
          if ((state == S_N4 && degen) || (state == S_DIV && dx_done && dy_done)) begin
            result_valid        <= 1'b1;
            result.gauss_index  <= g;
            result.basis_index  <= n;
            result.point_x      <= px;
            result.point_y      <= py;
            result.jacobian_det <= det;
            result.deriv_x      <= degen ? '0 : dx_q;
            result.deriv_y      <= degen ? '0 : dy_q;
            result.degenerate   <= degen;
            result.last         <= (g == 2'd3) && (n == 2'd3);
            if (n == 2'd3) begin
              if (g == 2'd3) begin
                state <= S_IDLE;
              end else begin
                g     <= g + 1'b1;
                k     <= '0;
                state <= S_ACC;
              end
            end else begin
              n     <= n + 1'b1;
              state <= S_N0;
            end
          end else begin
            state <= S_DIV;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/bilinear_quad_element_map_core.sv =====
// Top level of the bilinear quad element map: input queue and back end sequencer.
// An element beat is taken when start is high and busy is low; a two-deep queue lets
// up to two elements wait while one is worked. Each element gives sixteen result beats
// in gauss-major order, each shown for one cycle under result_valid; the receiver
// cannot stall. An element is taken from the queue, then each Gauss point runs a
// shared-multiplier accumulation, a drain, a rounding step and three determinant
// steps, and each basis function runs five numerator steps, a 34-step radix-2
// division of both derivatives and the result beat. At a Gauss point with a zero
// determinant the divisions are skipped.
module bilinear_quad_element_map_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  bqem_pkg::in_t  corners,
  output logic           result_valid,
  output bqem_pkg::out_t result
);

  logic          q_valid;
  logic          q_pop;
  bqem_pkg::in_t q_data;

  bqem_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .corners(corners),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  bqem_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .result_valid(result_valid), .result(result)
  );

endmodule

// ===== sv/bqem_checker.sv =====
// Port-level checks on the element map core and its bind.
module bqem_checker (
  input logic           clk,
  input logic           rst,
  input logic           busy,
  input logic           result_valid,
  input bqem_pkg::out_t result
);

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |->
      result.gauss_index == 2'd3 && result.basis_index == 2'd3)
    else $error("last beat not at final gauss and basis");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |->
      result.deriv_x == '0 && result.deriv_y == '0 && result.jacobian_det == '0)
    else $error("degenerate beat with nonzero values");

  a_basis_seq: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=> !result_valid || result.basis_index != 2'd0 ||
      $past(result.basis_index) == 2'd3)
    else $error("basis order broken");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && !busy)
    else $error("activity right after reset");

endmodule

bind bilinear_quad_element_map_core bqem_checker u_bqem_checker (
  .clk(clk), .rst(rst), .busy(busy),
  .result_valid(result_valid), .result(result)
);
